[sv/lse_pkg.sv]
`timescale 1ns / 1ps

package lse_pkg;

	localparam int PixelWidth = 24;
	localparam int ValueWidth = 32;
	localparam int ByteWidth  = 8;
	localparam int CountWidth = 5;

	// bit positions of the channel lsbs inside a packed pixel
	localparam int RedLsb   = 16;
	localparam int GreenLsb = 8;
	localparam int BlueLsb  = 0;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	localparam logic [1:0] KIND_NAME = 2'd0;
	localparam logic [1:0] KIND_SIZE = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;

	localparam logic [CountWidth-1:0] BYTE_BITS = CountWidth'(ByteWidth);

	typedef enum logic [1:0] {
		PH_NAME = 2'd0,
		PH_SIZE = 2'd1,
		PH_DATA = 2'd2,
		PH_DONE = 2'd3
	} lse_phase_t;

	typedef struct packed {
		logic                  frame_start;
		logic [PixelWidth-1:0] pixel;
	} lse_item_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [ValueWidth-1:0] value;
		logic                  last;
	} lse_result_t;

endpackage

[sv/lse_in_reg.sv]
`timescale 1ns / 1ps

module lse_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lse_pkg::lse_item_t in_item,
	output logic              valid_s1,
	output lse_pkg::lse_item_t item_s1,
	input  logic              take_s1
);

	// stage empties whenever the decoder takes it, so a full stage still refills
	assign in_ready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

[sv/lse_decoder.sv]
`timescale 1ns / 1ps

module lse_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  lse_pkg::lse_item_t   item_s1,
	output logic                 take_s1,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lse_pkg::lse_result_t result_s2
);

	lse_pkg::lse_phase_t                 phase_q, phase_d, phase_cur;
	logic [1:0]                          chan_q, chan_d, chan_cur;
	logic [lse_pkg::CountWidth-1:0]      count_q, count_d, count_cur, count_inc;
	logic [lse_pkg::ValueWidth-1:0]      shift_q, shift_d, shift_cur, shift_inc;
	logic [lse_pkg::ValueWidth-1:0]      left_q, left_d, left_cur, left_dec;
	logic                                pix_bit;
	logic                                emit;
	lse_pkg::lse_result_t                res_d;
	logic                                valid_s2;
	logic                                fire;

	assign take_s1   = !valid_s2 || out_ready;
	assign fire      = valid_s1 && take_s1;
	assign out_valid = valid_s2;

	always_comb begin
		phase_cur = phase_q;
		chan_cur  = chan_q;
		count_cur = count_q;
		shift_cur = shift_q;
		left_cur  = left_q;
		// frame start restarts the decoder before this pixel is used
		if (item_s1.frame_start) begin
			phase_cur = lse_pkg::PH_NAME;
			chan_cur  = lse_pkg::CH_RED;
			count_cur = '0;
			shift_cur = '0;
			left_cur  = '0;
		end

		case (chan_cur)
			lse_pkg::CH_RED:   pix_bit = item_s1.pixel[lse_pkg::RedLsb];
			lse_pkg::CH_GREEN: pix_bit = item_s1.pixel[lse_pkg::GreenLsb];
			default:           pix_bit = item_s1.pixel[lse_pkg::BlueLsb];
		endcase

		shift_inc = {shift_cur[lse_pkg::ValueWidth-2:0], pix_bit};
		count_inc = count_cur + 1'b1;
		left_dec  = left_cur - 1'b1;

		phase_d = phase_cur;
		chan_d  = (chan_cur == lse_pkg::CH_BLUE) ? lse_pkg::CH_RED : chan_cur + 1'b1;
		count_d = count_inc;
		shift_d = shift_inc;
		left_d  = left_cur;
		emit    = 1'b0;
		res_d.kind  = lse_pkg::KIND_NAME;
		res_d.value = {{(lse_pkg::ValueWidth-lse_pkg::ByteWidth){1'b0}},
			shift_inc[lse_pkg::ByteWidth-1:0]};
		res_d.last  = 1'b0;

		case (phase_cur)
			lse_pkg::PH_NAME: begin
				if (count_inc == lse_pkg::BYTE_BITS) begin
					count_d = '0;
					shift_d = '0;
					// zero byte ends the name and is not sent
					if (shift_inc[lse_pkg::ByteWidth-1:0] == '0) begin
						phase_d = lse_pkg::PH_SIZE;
					end else begin
						emit = 1'b1;
					end
				end
			end
			lse_pkg::PH_SIZE: begin
				// count wraps to zero after 32 bits
				if (count_inc == '0) begin
					shift_d     = '0;
					left_d      = shift_inc;
					emit        = 1'b1;
					res_d.kind  = lse_pkg::KIND_SIZE;
					res_d.value = shift_inc;
					res_d.last  = (shift_inc == '0);
					phase_d     = (shift_inc == '0) ? lse_pkg::PH_DONE : lse_pkg::PH_DATA;
				end
			end
			lse_pkg::PH_DATA: begin
				if (count_inc == lse_pkg::BYTE_BITS) begin
					count_d    = '0;
					shift_d    = '0;
					left_d     = left_dec;
					emit       = 1'b1;
					res_d.kind = lse_pkg::KIND_DATA;
					res_d.last = (left_dec == '0);
					if (left_dec == '0) begin
						phase_d = lse_pkg::PH_DONE;
					end
				end
			end
			default: begin
				// done: pixel ignored, nothing moves
				chan_d  = chan_cur;
				count_d = count_cur;
				shift_d = shift_cur;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lse_pkg::PH_NAME;
			chan_q   <= lse_pkg::CH_RED;
			count_q  <= '0;
			shift_q  <= '0;
			left_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				chan_q  <= chan_d;
				count_q <= count_d;
				shift_q <= shift_d;
				left_q  <= left_d;
			end
			if (take_s1) begin
				valid_s2 <= fire && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			result_s2 <= res_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q == lse_pkg::PH_DONE && !item_s1.frame_start)
		|=> phase_q == lse_pkg::PH_DONE)
		else $error("done phase left without frame start");

	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lse_pkg::PH_DATA |-> left_q != '0)
		else $error("payload phase with no bytes left");

	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lse_pkg::PH_NAME || phase_q == lse_pkg::PH_DATA)
		|-> count_q < lse_pkg::BYTE_BITS)
		else $error("bit count past a byte");

	a_name_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.kind == lse_pkg::KIND_NAME) |-> !result_s2.last)
		else $error("name character marked last");
`endif

endmodule

[sv/lsb_stego_extractor_top.sv]
`timescale 1ns / 1ps

// lsb stego extractor
// input channel: in_valid/in_ready with frame_start and a packed 24-bit pixel.
// one lsb per pixel is taken from red, green, blue in turn; frame_start restarts
// decoding at red with that pixel.
// output channel: out_valid/out_ready with kind (name char, size word, payload
// byte), value and last. name ends at a zero byte, which is not sent; then the
// 32-bit size, then that many payload bytes, the final one marked last
// (a zero size is marked last itself). afterwards pixels are dropped until the
// next frame_start.
// timing: one item per clock sustained while out_ready stays high. a pixel that completes a
// result goes through the input register, then is decoded into the result register, and a
// stalled receiver can hold it in either. at most one result per item.
// when the receiver stalls with a result waiting, the result register holds; the input
// register takes at most one more item, then in_ready stays low until the result is taken.
// reset: asynchronous, clears both valid flags and the decoder state, so the
// first pixel after reset decodes as the start of a frame.

module lsb_stego_extractor_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              frame_start,
	input  logic [lse_pkg::PixelWidth-1:0]    pixel,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        kind,
	output logic [lse_pkg::ValueWidth-1:0]    value,
	output logic                              last
);

	lse_pkg::lse_item_t   in_item;
	lse_pkg::lse_item_t   item_s1;
	lse_pkg::lse_result_t result_s2;
	logic                 valid_s1;
	logic                 take_s1;

	assign in_item.frame_start = frame_start;
	assign in_item.pixel       = pixel;

	lse_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take_s1  (take_s1)
	);

	lse_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.take_s1   (take_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_s2 (result_s2)
	);

	assign kind  = result_s2.kind;
	assign value = result_s2.value;
	assign last  = result_s2.last;

endmodule

[tb/tb_lsb_stego_extractor_top.sv]
`timescale 1ns / 1ps

module tb_lsb_stego_extractor_top;

	localparam int StallLimit   = 3000;
	localparam int HoldCycles   = 300;
	localparam int RandomPixels = 1250;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic                           frame_start;
	logic [lse_pkg::PixelWidth-1:0] pixel;
	logic                           out_valid;
	logic                           out_ready;
	logic [1:0]                     kind;
	logic [lse_pkg::ValueWidth-1:0] value;
	logic                           last;

	lsb_stego_extractor_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.frame_start(frame_start),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.value      (value),
		.last       (last)
	);

	// decoder shadow state
	lse_pkg::lse_phase_t            dec_phase = lse_pkg::PH_NAME;
	logic [1:0]                     chan_sel = lse_pkg::CH_RED;
	logic [lse_pkg::CountWidth-1:0] bit_cnt = '0;
	logic [lse_pkg::ValueWidth-1:0] shift_acc = '0;
	logic [lse_pkg::ValueWidth-1:0] bytes_remaining = '0;

	lse_pkg::lse_result_t expected_results[$];
	lse_pkg::lse_result_t exp_r;
	logic                 frame_bits[$];

	int in_gap_max = 0;
	int out_gap_max = 0;
	bit hold_req = 0;
	int mismatch_count = 0;
	int pixels_sent = 0;
	int frames_sent = 0;
	int name_seen = 0;
	int size_seen = 0;
	int data_seen = 0;
	int stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic predict_pixel(input logic fs, input logic [lse_pkg::PixelWidth-1:0] px);
		logic                 bit_in;
		lse_pkg::lse_result_t r;
		if (fs) begin
			dec_phase = lse_pkg::PH_NAME;
			chan_sel = lse_pkg::CH_RED;
			bit_cnt = '0;
			shift_acc = '0;
			bytes_remaining = '0;
		end
		if (dec_phase != lse_pkg::PH_DONE) begin
			case (chan_sel)
				lse_pkg::CH_RED:   bit_in = px[lse_pkg::RedLsb];
				lse_pkg::CH_GREEN: bit_in = px[lse_pkg::GreenLsb];
				default:           bit_in = px[lse_pkg::BlueLsb];
			endcase
			chan_sel = (chan_sel == lse_pkg::CH_BLUE) ? lse_pkg::CH_RED : chan_sel + 2'd1;
			shift_acc = {shift_acc[lse_pkg::ValueWidth-2:0], bit_in};
			bit_cnt = bit_cnt + 1'b1;
			case (dec_phase)
				lse_pkg::PH_NAME: begin
					if (bit_cnt == lse_pkg::BYTE_BITS) begin
						bit_cnt = '0;
						// zero byte ends the name and is not sent
						if (shift_acc[lse_pkg::ByteWidth-1:0] == '0) begin
							dec_phase = lse_pkg::PH_SIZE;
						end else begin
							r.kind = lse_pkg::KIND_NAME;
							r.value = {24'd0, shift_acc[lse_pkg::ByteWidth-1:0]};
							r.last = 1'b0;
							expected_results.push_back(r);
						end
						shift_acc = '0;
					end
				end
				lse_pkg::PH_SIZE: begin
					// count wraps to zero after 32 bits
					if (bit_cnt == '0) begin
						r.kind = lse_pkg::KIND_SIZE;
						r.value = shift_acc;
						r.last = (shift_acc == '0);
						expected_results.push_back(r);
						bytes_remaining = shift_acc;
						dec_phase = (shift_acc == '0) ? lse_pkg::PH_DONE : lse_pkg::PH_DATA;
						shift_acc = '0;
					end
				end
				default: begin
					if (bit_cnt == lse_pkg::BYTE_BITS) begin
						bytes_remaining = bytes_remaining - 1;
						r.kind = lse_pkg::KIND_DATA;
						r.value = {24'd0, shift_acc[lse_pkg::ByteWidth-1:0]};
						r.last = (bytes_remaining == '0);
						expected_results.push_back(r);
						if (bytes_remaining == '0)
							dec_phase = lse_pkg::PH_DONE;
						bit_cnt = '0;
						shift_acc = '0;
					end
				end
			endcase
		end
	endtask

	task automatic send_pixel(input logic fs, input logic [lse_pkg::PixelWidth-1:0] px);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		frame_start <= fs;
		pixel <= px;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_pixel(fs, px);
		pixels_sent++;
	endtask

	task automatic push_byte(input logic [lse_pkg::ByteWidth-1:0] b);
		for (int i = lse_pkg::ByteWidth - 1; i >= 0; i--)
			frame_bits.push_back(b[i]);
	endtask

	// builds name, terminator, size and payload, then hides one bit per pixel
	task automatic send_frame(input int name_len, input logic [lse_pkg::ValueWidth-1:0] size,
			input int payload_bytes, input int cut_bits, input int trailing, input logic fs);
		logic [lse_pkg::PixelWidth-1:0] px;
		int                             n;
		frame_bits.delete();
		repeat (name_len) push_byte(lse_pkg::ByteWidth'($urandom_range(1, 255)));
		push_byte('0);
		for (int i = lse_pkg::ValueWidth - 1; i >= 0; i--)
			frame_bits.push_back(size[i]);
		repeat (payload_bytes) push_byte(lse_pkg::ByteWidth'($urandom_range(0, 255)));
		n = (cut_bits > 0 && cut_bits < frame_bits.size()) ? cut_bits : frame_bits.size();
		for (int i = 0; i < n; i++) begin
			px = lse_pkg::PixelWidth'($urandom());
			case (i % 3)
				0:       px[lse_pkg::RedLsb] = frame_bits[i];
				1:       px[lse_pkg::GreenLsb] = frame_bits[i];
				default: px[lse_pkg::BlueLsb] = frame_bits[i];
			endcase
			send_pixel(fs && (i == 0), px);
		end
		repeat (trailing) send_pixel(1'b0, lse_pkg::PixelWidth'($urandom()));
		frames_sent++;
	endtask

	function automatic int pick_gap_max();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 3;
			default: return 13;
		endcase
	endfunction

	task automatic test_startup_without_frame_start();
		// empty name, zero size, then pixels in the done phase
		repeat (40) send_pixel(1'b0, '0);
		repeat (4) send_pixel(1'b0, {lse_pkg::PixelWidth{1'b1}});
	endtask

	task automatic test_long_ones_name();
		send_pixel(1'b1, {lse_pkg::PixelWidth{1'b1}});
		repeat (31) send_pixel(1'b0, {lse_pkg::PixelWidth{1'b1}});
	endtask

	task automatic test_zero_size_frame();
		send_frame(2, '0, 0, 0, 6, 1'b1);
	endtask

	task automatic test_small_file();
		send_frame(1, 32'd2, 2, 0, 5, 1'b1);
		send_frame(0, 32'd1, 1, 0, 0, 1'b1);
	endtask

	task automatic test_restart_mid_frame();
		send_frame(3, 32'd4, 4, 30, 0, 1'b1);
		send_frame(1, 32'hFFFF_FFFF, 2, 0, 0, 1'b1);
		send_frame(1, 32'd1, 1, 0, 3, 1'b1);
	endtask

	task automatic test_output_backpressure();
		in_gap_max = 0;
		out_gap_max = 0;
		hold_req = 1'b1;
		send_frame(2, 32'd10, 10, 0, 2, 1'b1);
	endtask

	task automatic test_random_frames();
		int start;
		int name_len;
		int payload;
		int cut;
		logic [lse_pkg::ValueWidth-1:0] size;
		start = pixels_sent;
		while (pixels_sent - start < RandomPixels) begin
			in_gap_max = pick_gap_max();
			out_gap_max = pick_gap_max();
			if ($urandom_range(0, 9) == 0) begin
				// noise with a rare restart
				repeat ($urandom_range(1, 20))
					send_pixel($urandom_range(0, 15) == 0, lse_pkg::PixelWidth'($urandom()));
			end else begin
				name_len = $urandom_range(0, 4);
				if ($urandom_range(0, 5) == 0) begin
					size = $urandom();
					payload = $urandom_range(0, 3);
				end else begin
					size = $urandom_range(0, 6);
					payload = size;
				end
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : 0;
				send_frame(name_len, size, payload, cut, $urandom_range(0, 5), 1'b1);
			end
		end
	endtask

	// receiver
	initial begin
		int gap;
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end
			gap = $urandom_range(0, out_gap_max);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected item: kind %0d value %0h last %0b", kind, value, last);
				mismatch_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (kind !== exp_r.kind) begin
					$error("kind: expected %0d, got %0d", exp_r.kind, kind);
					mismatch_count++;
				end
				if (value !== exp_r.value) begin
					$error("value: expected %0h, got %0h", exp_r.value, value);
					mismatch_count++;
				end
				if (last !== exp_r.last) begin
					$error("last: expected %0b, got %0b", exp_r.last, last);
					mismatch_count++;
				end
				case (exp_r.kind)
					lse_pkg::KIND_NAME: name_seen++;
					lse_pkg::KIND_SIZE: size_seen++;
					default:            data_seen++;
				endcase
			end
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= StallLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		frame_start <= 1'b0;
		pixel <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_startup_without_frame_start();
		test_long_ones_name();
		test_zero_size_frame();
		test_small_file();
		test_restart_mid_frame();
		test_output_backpressure();
		test_random_frames();

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d pixels in %0d frames, with restarts, truncation and long stalls",
			pixels_sent, frames_sent);
		$display("checked %0d name chars, %0d size words, %0d payload bytes",
			name_seen, size_seen, data_seen);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
sv/lse_pkg.sv
sv/lse_in_reg.sv
sv/lse_decoder.sv
sv/lsb_stego_extractor_top.sv
tb/tb_lsb_stego_extractor_top.sv
